>>> hdl/sensor_link_command_responder_unit_defines.svh
// assertion macros shared by the rtl files
`ifndef SENSOR_LINK_COMMAND_RESPONDER_UNIT_DEFINES_SVH
`define SENSOR_LINK_COMMAND_RESPONDER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SLCR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slcr assertion failed");
`define SLCR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slcr assertion failed");
`else
`define SLCR_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SLCR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> hdl/slcr_pkg.sv
package slcr_pkg;

  localparam logic [7:0] KIND_SHORT    = 8'h06;
  localparam logic [7:0] KIND_LONG     = 8'h0F;
  localparam logic [7:0] KIND_CFG      = 8'h09;
  localparam logic [7:0] KIND_QUERY    = 8'h08;

  localparam logic [7:0] HEAD_STATUS   = 8'h06;
  localparam logic [7:0] HEAD_ANGLE    = 8'h0C;
  localparam logic [7:0] HEAD_SECOND   = 8'hC2;
  localparam logic [7:0] MATCH_BYTE1   = 8'h42;

  localparam logic [7:0] SUB_PING      = 8'h66;
  localparam logic [7:0] SUB_ANGLE     = 8'h67;
  localparam logic [7:0] SUB_RESTORE   = 8'h68;

  localparam logic [7:0] STAT_SHORT_OK   = 8'h64;
  localparam logic [7:0] STAT_SHORT_BAD  = 8'hE4;
  localparam logic [7:0] STAT_FILL       = 8'h88;
  localparam logic [7:0] STAT_LONG_OK    = 8'h61;
  localparam logic [7:0] STAT_LONG_BAD   = 8'hE0;
  localparam logic [7:0] STAT_CFG_OK     = 8'h65;
  localparam logic [7:0] STAT_CFG_BAD    = 8'hE5;
  localparam logic [7:0] STAT_QUERY_BAD1 = 8'hE6;
  localparam logic [7:0] STAT_QUERY_BAD2 = 8'hCB;
  localparam logic [7:0] STAT_UNKNOWN0   = 8'h12;
  localparam logic [7:0] STAT_UNKNOWN1   = 8'h34;
  localparam logic [7:0] STAT_UNKNOWN2   = 8'h56;
  localparam logic [7:0] RESTORE_B0      = 8'h02;
  localparam logic [7:0] RESTORE_B1      = 8'hC0;
  localparam logic [7:0] RESTORE_B2      = 8'h15;

  localparam logic [3:0] SUM_FIRST_IDX = 4'd6;
  localparam logic [3:0] BODY_POS      = 4'd4;
  localparam logic [3:0] STATUS_LAST   = 4'd6;
  localparam logic [3:0] ANGLE_LAST    = 4'd12;

  typedef enum logic {
    ST_COLLECT,
    ST_SEND
  } state_t;

  typedef enum logic [1:0] {
    RM_STATUS,
    RM_ANGLE,
    RM_RESTORE
  } reply_mode_t;

  typedef struct packed {
    logic take_byte;
    logic send_byte;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic reply_last;
  } dp_stat_t;

  function automatic logic kind_known(input logic [7:0] kind);
    return (kind == KIND_SHORT) || (kind == KIND_LONG) ||
           (kind == KIND_CFG) || (kind == KIND_QUERY);
  endfunction

  function automatic logic [3:0] last_index(input logic [7:0] kind);
    logic [3:0] idx;
    unique case (kind)
      KIND_SHORT: idx = 4'd6;
      KIND_LONG:  idx = 4'd15;
      KIND_CFG:   idx = 4'd9;
      KIND_QUERY: idx = 4'd8;
      default:    idx = 4'd0;
    endcase
    return idx;
  endfunction

endpackage

>>> hdl/slcr_rx_if.sv
interface slcr_rx_if;
  logic               valid;
  logic               ready;
  logic [7:0]         rx_byte;
  logic signed [11:0] pitch_tenths;
  logic signed [11:0] roll_tenths;
  logic signed [11:0] yaw_tenths;

  modport source (
    output valid, rx_byte, pitch_tenths, roll_tenths, yaw_tenths,
    input  ready
  );
  modport sink (
    input  valid, rx_byte, pitch_tenths, roll_tenths, yaw_tenths,
    output ready
  );
endinterface

>>> hdl/slcr_tx_if.sv
interface slcr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_of_reply;

  modport source (
    output valid, tx_byte, last_of_reply,
    input  ready
  );
  modport sink (
    input  valid, tx_byte, last_of_reply,
    output ready
  );
endinterface

>>> hdl/sensor_link_command_responder_unit.sv
// latency: the first reply byte is offered the cycle after the byte that completes a frame
// throughput: one received byte per cycle while collecting, one reply byte per cycle while
// sending and tx.ready is high; a reply is 3, 7 or 13 bytes and no byte is taken meanwhile
// the reply run is set by a byte position counter that walks the reply layout
// reset: synchronous rst returns to collecting with byte index and sums cleared;
// frame store contents are not cleared
module sensor_link_command_responder_unit import slcr_pkg::*; (
  input logic   clk,
  input logic   rst,
  slcr_rx_if.sink   rx,
  slcr_tx_if.source tx
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  slcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .out_ready (tx.ready),
    .stat      (stat),
    .in_ready  (rx.ready),
    .out_valid (tx.valid),
    .cmd       (cmd)
  );

  slcr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .rx_byte       (rx.rx_byte),
    .pitch_tenths  (rx.pitch_tenths),
    .roll_tenths   (rx.roll_tenths),
    .yaw_tenths    (rx.yaw_tenths),
    .stat          (stat),
    .tx_byte       (tx.tx_byte),
    .last_of_reply (tx.last_of_reply)
  );

endmodule

>>> hdl/slcr_ctrl.sv
`include "sensor_link_command_responder_unit_defines.svh"

module slcr_ctrl import slcr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output logic     in_ready,
  output logic     out_valid,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (in_valid && stat.frame_done) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_ready && stat.reply_last) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    unique case (state)
      ST_COLLECT: in_ready  = 1'b1;
      ST_SEND:    out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
    cmd.take_byte = in_valid && in_ready;
    cmd.send_byte = out_valid && out_ready;
  end

  `SLCR_ASSERT_SAME(a_no_overlap, clk, rst, 1'b1, !(in_ready && out_valid))
  `SLCR_ASSERT_NEXT(a_reply_starts, clk, rst, cmd.take_byte && stat.frame_done, out_valid)
  `SLCR_ASSERT_NEXT(a_reply_ends, clk, rst, cmd.send_byte && stat.reply_last, in_ready)

endmodule

>>> hdl/slcr_dp.sv
`include "sensor_link_command_responder_unit_defines.svh"

module slcr_dp import slcr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [7:0]         rx_byte,
  input  logic signed [11:0] pitch_tenths,
  input  logic signed [11:0] roll_tenths,
  input  logic signed [11:0] yaw_tenths,
  output dp_stat_t           stat,
  output logic [7:0]         tx_byte,
  output logic               last_of_reply
);

  logic [7:0]  frame_store [16];
  logic [3:0]  byte_index;
  logic [7:0]  run_sum;
  reply_mode_t mode;
  logic [3:0]  pos;
  logic [7:0]  tail [3];
  logic [7:0]  tx_sum;
  logic [11:0] pitch;
  logic [11:0] roll;
  logic [11:0] yaw;

  logic [7:0]  kind;
  logic        known;
  logic        done;
  logic        sum_ok;
  logic        short_ok;
  reply_mode_t mode_next;
  logic [7:0]  tail_next [3];
  logic [15:0] pitch_ext;
  logic [15:0] roll_ext;
  logic [15:0] yaw_ext;

  assign kind     = (byte_index == 4'd0) ? rx_byte : frame_store[0];
  assign known    = kind_known(kind);
  assign done     = known && (byte_index == last_index(kind));
  assign sum_ok   = (run_sum == rx_byte);
  assign short_ok = (frame_store[1] == MATCH_BYTE1) && (frame_store[2] == 8'h00);

  // reply contents decided on the byte that completes the frame
  always_comb begin
    mode_next    = RM_STATUS;
    tail_next[0] = STAT_UNKNOWN0;
    tail_next[1] = STAT_UNKNOWN1;
    tail_next[2] = STAT_UNKNOWN2;
    unique case (kind)
      KIND_SHORT: begin
        if (short_ok) begin
          tail_next[0] = STAT_SHORT_OK;
          tail_next[1] = rx_byte;
          tail_next[2] = STAT_SHORT_OK + rx_byte;
        end else begin
          tail_next[0] = STAT_SHORT_BAD;
          tail_next[1] = STAT_FILL;
          tail_next[2] = STAT_FILL;
        end
      end
      KIND_LONG: begin
        if (sum_ok) begin
          tail_next[0] = STAT_LONG_OK;
          tail_next[1] = 8'h00;
          tail_next[2] = STAT_LONG_OK;
        end else begin
          tail_next[0] = STAT_LONG_BAD;
          tail_next[1] = STAT_FILL;
          tail_next[2] = STAT_FILL;
        end
      end
      KIND_CFG: begin
        if (sum_ok) begin
          tail_next[0] = STAT_CFG_OK;
          tail_next[1] = frame_store[7];
          tail_next[2] = STAT_CFG_OK + frame_store[7];
        end else begin
          tail_next[0] = STAT_CFG_BAD;
          tail_next[1] = 8'h00;
          tail_next[2] = STAT_CFG_BAD;
        end
      end
      KIND_QUERY: begin
        priority if (!sum_ok) begin
          tail_next[0] = STAT_CFG_BAD;
          tail_next[1] = STAT_QUERY_BAD1;
          tail_next[2] = STAT_QUERY_BAD2;
        end else if (frame_store[6] == SUB_PING) begin
          tail_next[0] = SUB_PING;
          tail_next[1] = 8'h00;
          tail_next[2] = SUB_PING;
        end else if (frame_store[6] == SUB_ANGLE) begin
          mode_next = RM_ANGLE;
        end else if (frame_store[6] == SUB_RESTORE) begin
          mode_next    = RM_RESTORE;
          tail_next[0] = RESTORE_B0;
          tail_next[1] = RESTORE_B1;
          tail_next[2] = RESTORE_B2;
        end else begin
          tail_next[0] = STAT_UNKNOWN0;
          tail_next[1] = STAT_UNKNOWN1;
          tail_next[2] = STAT_UNKNOWN2;
        end
      end
      default: mode_next = RM_STATUS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      frame_store[byte_index] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 4'd0;
      run_sum    <= 8'h00;
    end else if (cmd.take_byte && known) begin
      if (done) begin
        byte_index <= 4'd0;
        run_sum    <= 8'h00;
      end else begin
        byte_index <= byte_index + 4'd1;
        if (byte_index >= SUM_FIRST_IDX) begin
          run_sum <= run_sum + rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= RM_STATUS;
      pos    <= 4'd0;
      tx_sum <= 8'h00;
    end else if (cmd.take_byte && done) begin
      mode   <= mode_next;
      pos    <= (mode_next == RM_RESTORE) ? BODY_POS : 4'd0;
      tx_sum <= 8'h00;
    end else if (cmd.send_byte) begin
      if (!stat.reply_last) begin
        pos <= pos + 4'd1;
      end
      if (pos >= BODY_POS) begin
        tx_sum <= tx_sum + tx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && done) begin
      tail[0] <= tail_next[0];
      tail[1] <= tail_next[1];
      tail[2] <= tail_next[2];
      pitch   <= pitch_tenths;
      roll    <= roll_tenths;
      yaw     <= yaw_tenths;
    end
  end

  assign pitch_ext = {{4{pitch[11]}}, pitch};
  assign roll_ext  = {{4{roll[11]}}, roll};
  assign yaw_ext   = {{4{yaw[11]}}, yaw};

  always_comb begin
    tx_byte = 8'h00;
    unique case (pos)
      4'd0:  tx_byte = (mode == RM_ANGLE) ? HEAD_ANGLE : HEAD_STATUS;
      4'd1:  tx_byte = HEAD_SECOND;
      4'd2:  tx_byte = frame_store[2];
      4'd3:  tx_byte = frame_store[3];
      4'd4:  tx_byte = (mode == RM_ANGLE) ? SUB_ANGLE : tail[0];
      4'd5:  tx_byte = (mode == RM_ANGLE) ? frame_store[7] : tail[1];
      4'd6:  tx_byte = (mode == RM_ANGLE) ? pitch_ext[15:8] : tail[2];
      4'd7:  tx_byte = pitch_ext[7:0];
      4'd8:  tx_byte = roll_ext[15:8];
      4'd9:  tx_byte = roll_ext[7:0];
      4'd10: tx_byte = yaw_ext[15:8];
      4'd11: tx_byte = yaw_ext[7:0];
      4'd12: tx_byte = tx_sum;
      default: tx_byte = 8'h00;
    endcase
  end

  assign stat.frame_done = done;
  assign stat.reply_last = (mode == RM_ANGLE) ? (pos == ANGLE_LAST) : (pos == STATUS_LAST);
  assign last_of_reply   = stat.reply_last;

  `SLCR_ASSERT_SAME(a_pos_range, clk, rst, 1'b1, pos <= ANGLE_LAST)
  `SLCR_ASSERT_SAME(a_short_pos, clk, rst, mode != RM_ANGLE, pos <= STATUS_LAST)
  `SLCR_ASSERT_SAME(a_index_kind, clk, rst, byte_index != 4'd0, kind_known(frame_store[0]))

endmodule
